[design/pkme_pkg.sv]
// shared constants and types of the pawn and king network evaluator
package pkme_pkg;

   localparam int FEATURE_COUNT = 224;
   localparam int FEAT_W        = 8;
   localparam int SQ_W          = 6;
   localparam int SQ_LAST       = 63;
   localparam int PAWN_OFS      = 8;
   localparam int KING_OFS      = 48;
   localparam int COLOUR_OFS    = 112;
   localparam int HID_W         = 23;
   localparam int RECIP_SHIFT   = 22;
   localparam int ADDR_W        = 13;

   localparam logic [63:0]        BACK_RANKS = 64'hFF00_0000_0000_00FF;
   localparam logic signed [24:0] HIDDEN_MAX = 25'sh7F_FFFF;

   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_EVAL = 1'b1;

   typedef struct packed {
      logic wr_feat;
      logic wr_bias;
      logic wr_ow0;
      logic wr_ow1;
      logic init;
      logic rd_a;
      logic rd_b;
      logic relu;
      logic mul;
   } lane_ctl_type;

endpackage

[design/pkme_lane.sv]
// one hidden neuron: weight column, accumulator, relu and output products
module pkme_lane import pkme_pkg::*; #(
   parameter int WEIGHT_BITS = 16,
   parameter int LANE_W      = 5,
   parameter int LANE_ID     = 0
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  lane_ctl_type                           ctl,
   input  logic [LANE_W-1:0]                      wr_lane,
   input  logic [FEAT_W-1:0]                      wr_addr,
   input  logic signed [WEIGHT_BITS-1:0]          wr_data,
   input  logic [FEAT_W-1:0]                      rd_addr_a,
   input  logic [FEAT_W-1:0]                      rd_addr_b,
   output logic signed [HID_W+WEIGHT_BITS:0]      prod0,
   output logic signed [HID_W+WEIGHT_BITS:0]      prod1
);

   localparam int ACC_BITS = WEIGHT_BITS + 7;

   logic signed [WEIGHT_BITS-1:0] mem [FEATURE_COUNT];
   logic signed [WEIGHT_BITS-1:0] rdata_a_ff, rdata_b_ff;
   logic                          ena_ff, enb_ff;
   logic signed [WEIGHT_BITS-1:0] bias_ff, ow0_ff, ow1_ff;
   logic signed [ACC_BITS-1:0]    acc_ff, acc_in, add_a, add_b;
   logic [HID_W-1:0]              hid_ff, hid_in;
   logic signed [HID_W+WEIGHT_BITS:0] prod0_ff, prod1_ff;
   logic                          sel;

   assign sel = (wr_lane == LANE_W'(LANE_ID));

   always_ff @(posedge clock) begin
      if (ctl.wr_feat && sel) begin
         mem[wr_addr] <= wr_data;
      end
      rdata_a_ff <= mem[rd_addr_a];
      rdata_b_ff <= mem[rd_addr_b];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ena_ff <= 1'b0;
         enb_ff <= 1'b0;
      end else begin
         ena_ff <= ctl.rd_a;
         enb_ff <= ctl.rd_b;
      end
   end

   assign add_a = ena_ff ? ACC_BITS'(rdata_a_ff) : '0;
   assign add_b = enb_ff ? ACC_BITS'(rdata_b_ff) : '0;

   always_comb begin
      acc_in = acc_ff;
      if (ctl.init) begin
         acc_in = ACC_BITS'(bias_ff);
      end else if (ena_ff || enb_ff) begin
         acc_in = acc_ff + add_a + add_b;
      end
   end

   always_comb begin
      if (acc_ff[ACC_BITS-1]) begin
         hid_in = '0;
      end else if (acc_ff > HIDDEN_MAX) begin
         hid_in = HIDDEN_MAX[HID_W-1:0];
      end else begin
         hid_in = HID_W'(acc_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.wr_bias && sel) bias_ff <= wr_data;
      if (ctl.wr_ow0 && sel) ow0_ff <= wr_data;
      if (ctl.wr_ow1 && sel) ow1_ff <= wr_data;
      acc_ff <= acc_in;
      if (ctl.relu) hid_ff <= hid_in;
      if (ctl.mul) begin
         prod0_ff <= $signed({1'b0, hid_ff}) * ow0_ff;
         prod1_ff <= $signed({1'b0, hid_ff}) * ow1_ff;
      end
   end

   assign prod0 = prod0_ff;
   assign prod1 = prod1_ff;

endmodule

[design/pawn_king_mlp_evaluator_unit.sv]
// top level: weight loading, feature scan, neuron lanes and output merge
// load transaction: accepted, then address decode (ST_LDIV) and write (ST_LWR)
// evaluate transaction: accepted, then ST_INIT, ST_SCAN, ST_DRAIN, ST_RELU, ST_MUL, ST_MERGE and ST_FIN in order
// the square scan walks all 64 squares, one square a cycle, two column reads per lane
// the merge walks the lanes, one lane a cycle; one transaction at a time
// synchronous reset clears control only; the weight store is undefined until written
module pawn_king_mlp_evaluator_unit import pkme_pkg::*; #(
   parameter int HIDDEN_NEURONS = 32,
   parameter int WEIGHT_BITS    = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic                req_opcode,
   input  logic [12:0]         req_weight_address,
   input  logic signed [15:0]  req_weight_value,
   input  logic [63:0]         req_pawn_squares,
   input  logic [63:0]         req_king_squares,
   input  logic [63:0]         req_black_squares,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic signed [15:0]  rsp_midgame_score,
   output logic signed [15:0]  rsp_endgame_score,
   output logic                rsp_bad_position
);

   localparam int LANE_W      = (HIDDEN_NEURONS > 1) ? $clog2(HIDDEN_NEURONS) : 1;
   localparam int PW          = HID_W + WEIGHT_BITS + 1;
   localparam int SW          = PW + LANE_W + 2;
   localparam int FEAT_WORDS  = FEATURE_COUNT * HIDDEN_NEURONS;
   localparam int HB_BASE     = FEAT_WORDS;
   localparam int OW_BASE     = HB_BASE + HIDDEN_NEURONS;
   localparam int OB_BASE     = OW_BASE + 2 * HIDDEN_NEURONS;
   localparam int RECIP       = ((1 << RECIP_SHIFT) + HIDDEN_NEURONS - 1) / HIDDEN_NEURONS;

   typedef enum logic [9:0] {
      ST_IDLE  = 10'b00_0000_0001,
      ST_LDIV  = 10'b00_0000_0010,
      ST_LWR   = 10'b00_0000_0100,
      ST_INIT  = 10'b00_0000_1000,
      ST_SCAN  = 10'b00_0001_0000,
      ST_DRAIN = 10'b00_0010_0000,
      ST_RELU  = 10'b00_0100_0000,
      ST_MUL   = 10'b00_1000_0000,
      ST_MERGE = 10'b01_0000_0000,
      ST_FIN   = 10'b10_0000_0000
   } state_type;

   state_type state_ff, state_in;

   logic [ADDR_W-1:0]             addr_ff;
   logic signed [WEIGHT_BITS-1:0] wval_ff;
   logic [10:0]                   quot_ff;
   logic [32:0]                   qprod;
   logic [ADDR_W-1:0]             rem, hb_off, ow_off;
   logic                          in_feat, in_bias, in_ow, in_ob0, in_ob1;
   logic signed [31:0]            v32;

   logic [63:0]        pawns_ff, kings_ff, black_ff;
   logic               back_ff;
   logic [SQ_W-1:0]    sq_ff;
   logic [1:0]         used_ff, kcnt_ff;
   logic               pawn_hit, king_hit, blk;
   logic [FEAT_W-1:0]  addr_a, addr_b;

   logic [LANE_W-1:0]  cnt_ff;
   logic signed [WEIGHT_BITS-1:0] obias0_ff, obias1_ff;
   logic signed [SW-1:0] sum0_ff, sum1_ff;

   logic                 rsp_valid_ff, rsp_valid_in, slot_free;
   logic signed [15:0]   mid_ff, end_ff, mid_in, end_in;
   logic                 bad_ff;

   lane_ctl_type         ctl;
   logic [LANE_W-1:0]    wr_lane;
   logic signed [PW-1:0] prod0 [HIDDEN_NEURONS];
   logic signed [PW-1:0] prod1 [HIDDEN_NEURONS];

   assign req_stall = (state_ff != ST_IDLE);
   assign slot_free = !rsp_valid_ff || !rsp_stall;

   // address decode of a load
   assign v32     = 32'(req_weight_value);
   assign qprod   = 33'(addr_ff) * 33'(RECIP);
   assign rem     = addr_ff - ADDR_W'(int'(quot_ff) * HIDDEN_NEURONS);
   assign hb_off  = addr_ff - ADDR_W'(HB_BASE);
   assign ow_off  = addr_ff - ADDR_W'(OW_BASE);
   assign in_feat = int'(addr_ff) < FEAT_WORDS;
   assign in_bias = !in_feat && int'(addr_ff) < OW_BASE;
   assign in_ow   = !in_feat && !in_bias && int'(addr_ff) < OB_BASE;
   assign in_ob0  = int'(addr_ff) == OB_BASE;
   assign in_ob1  = int'(addr_ff) == OB_BASE + 1;

   // square scan
   assign blk      = black_ff[sq_ff];
   assign pawn_hit = pawns_ff[sq_ff];
   assign king_hit = kings_ff[sq_ff] && (used_ff < 2'd2);
   assign addr_a   = FEAT_W'(sq_ff) - FEAT_W'(PAWN_OFS) + (blk ? FEAT_W'(COLOUR_OFS) : '0);
   assign addr_b   = FEAT_W'(sq_ff) + FEAT_W'(KING_OFS) + (blk ? FEAT_W'(COLOUR_OFS) : '0);

   always_comb begin
      ctl         = '0;
      wr_lane     = LANE_W'(rem);
      if (state_ff == ST_LWR) begin
         ctl.wr_feat = in_feat;
         ctl.wr_bias = in_bias;
         ctl.wr_ow0  = in_ow && !ow_off[0];
         ctl.wr_ow1  = in_ow && ow_off[0];
         if (in_bias) wr_lane = LANE_W'(hb_off);
         else if (in_ow) wr_lane = LANE_W'(ow_off >> 1);
      end
      ctl.init = (state_ff == ST_INIT);
      ctl.rd_a = (state_ff == ST_SCAN) && pawn_hit;
      ctl.rd_b = (state_ff == ST_SCAN) && king_hit;
      ctl.relu = (state_ff == ST_RELU);
      ctl.mul  = (state_ff == ST_MUL);
   end

   for (genvar i = 0; i < HIDDEN_NEURONS; i++) begin : g_lane
      pkme_lane #(
         .WEIGHT_BITS (WEIGHT_BITS),
         .LANE_W      (LANE_W),
         .LANE_ID     (i)
      ) u_lane (
         .clock     (clock),
         .reset     (reset),
         .ctl       (ctl),
         .wr_lane   (wr_lane),
         .wr_addr   (quot_ff[FEAT_W-1:0]),
         .wr_data   (wval_ff),
         .rd_addr_a (addr_a),
         .rd_addr_b (addr_b),
         .prod0     (prod0[i]),
         .prod1     (prod1[i])
      );
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = (req_opcode == OP_EVAL) ? ST_INIT : ST_LDIV;
         end
         ST_LDIV:  state_in = ST_LWR;
         ST_LWR:   state_in = ST_IDLE;
         ST_INIT:  state_in = ST_SCAN;
         ST_SCAN: begin
            if (sq_ff == SQ_W'(SQ_LAST)) state_in = ST_DRAIN;
         end
         ST_DRAIN: state_in = ST_RELU;
         ST_RELU:  state_in = ST_MUL;
         ST_MUL:   state_in = ST_MERGE;
         ST_MERGE: begin
            if (cnt_ff == LANE_W'(HIDDEN_NEURONS - 1)) state_in = ST_FIN;
         end
         ST_FIN: begin
            if (slot_free) state_in = ST_IDLE;
         end
         default:  state_in = ST_IDLE;
      endcase
   end

   // truncate toward zero and saturate
   function automatic logic signed [15:0] sat16(input logic signed [SW-1:0] s);
      logic signed [SW-1:0] q;
      q = s >>> 16;
      if (s[SW-1] && (s[15:0] != '0)) q = q + SW'(1);
      if (q > SW'(32767)) return 16'sh7FFF;
      if (q < -SW'(32768)) return -16'sh8000;
      return 16'(q);
   endfunction

   assign mid_in = sat16(sum0_ff);
   assign end_in = sat16(sum1_ff);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && !rsp_stall) rsp_valid_in = 1'b0;
      if (state_ff == ST_FIN && slot_free) rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && req_valid) begin
         addr_ff  <= req_weight_address;
         wval_ff  <= v32[WEIGHT_BITS-1:0];
         pawns_ff <= req_pawn_squares & ~BACK_RANKS;
         kings_ff <= req_king_squares;
         black_ff <= req_black_squares;
         back_ff  <= |(req_pawn_squares & BACK_RANKS);
      end
      if (state_ff == ST_LDIV) quot_ff <= qprod[RECIP_SHIFT +: 11];
      if (state_ff == ST_LWR) begin
         if (in_ob0) obias0_ff <= wval_ff;
         if (in_ob1) obias1_ff <= wval_ff;
      end
      if (state_ff == ST_INIT) begin
         sq_ff   <= '0;
         used_ff <= '0;
         kcnt_ff <= '0;
      end
      if (state_ff == ST_SCAN) begin
         sq_ff <= sq_ff + SQ_W'(1);
         if (king_hit) used_ff <= used_ff + 2'd1;
         if (kings_ff[sq_ff] && kcnt_ff != 2'd3) kcnt_ff <= kcnt_ff + 2'd1;
      end
      if (state_ff == ST_MUL) begin
         cnt_ff  <= '0;
         sum0_ff <= SW'(obias0_ff) <<< 8;
         sum1_ff <= SW'(obias1_ff) <<< 8;
      end
      if (state_ff == ST_MERGE) begin
         cnt_ff  <= cnt_ff + LANE_W'(1);
         sum0_ff <= sum0_ff + SW'(prod0[cnt_ff]);
         sum1_ff <= sum1_ff + SW'(prod1[cnt_ff]);
      end
      if (state_ff == ST_FIN && slot_free) begin
         mid_ff <= mid_in;
         end_ff <= end_in;
         bad_ff <= (kcnt_ff != 2'd2) || back_ff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_midgame_score = mid_ff;
   assign rsp_endgame_score = end_ff;
   assign rsp_bad_position  = bad_ff;

endmodule

[design/pkme_checker.sv]
// port-level checks of the evaluator and their binding to the top level
module pkme_checker import pkme_pkg::*; (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_stall,
   input logic               req_opcode,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic signed [15:0] rsp_midgame_score,
   input logic signed [15:0] rsp_endgame_score,
   input logic               rsp_bad_position
);

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_midgame_score)
         && $stable(rsp_endgame_score) && $stable(rsp_bad_position))
      else $error("stalled result changed");

   // a load transaction never produces a result
   a_load_silent: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_opcode == OP_LOAD && !rsp_valid |=> !rsp_valid)
      else $error("load produced a result");

   // an evaluate transaction keeps the input side busy
   a_eval_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_opcode == OP_EVAL |=> req_stall)
      else $error("evaluate did not stall input");

   // an evaluate result cannot appear in the cycle after acceptance
   a_eval_late: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_opcode == OP_EVAL && !rsp_valid |=> !rsp_valid)
      else $error("result too early");

endmodule

bind pawn_king_mlp_evaluator_unit pkme_checker u_pkme_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_valid),
   .req_stall         (req_stall),
   .req_opcode        (req_opcode),
   .rsp_valid         (rsp_valid),
   .rsp_stall         (rsp_stall),
   .rsp_midgame_score (rsp_midgame_score),
   .rsp_endgame_score (rsp_endgame_score),
   .rsp_bad_position  (rsp_bad_position)
);

[tb/pawn_king_mlp_evaluator_unit_checker.sv]
// checker of the pawn and king network evaluator: predicts and compares scores
`timescale 1ns / 100ps
module pawn_king_mlp_evaluator_unit_checker import pkme_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_stall,
   input  logic               req_opcode,
   input  logic [12:0]        req_weight_address,
   input  logic signed [15:0] req_weight_value,
   input  logic [63:0]        req_pawn_squares,
   input  logic [63:0]        req_king_squares,
   input  logic [63:0]        req_black_squares,
   input  logic               rsp_valid,
   input  logic               rsp_stall,
   input  logic signed [15:0] rsp_midgame_score,
   input  logic signed [15:0] rsp_endgame_score,
   input  logic               rsp_bad_position,
   output int                 fail_count,
   output int                 pending
);

   localparam int NEURONS    = 32;
   localparam int HBIAS_BASE = FEATURE_COUNT * NEURONS;
   localparam int OW_BASE    = HBIAS_BASE + NEURONS;
   localparam int OB_BASE    = OW_BASE + 2 * NEURONS;
   localparam int MAP_END    = OB_BASE + 2;

   typedef struct {
      logic signed [15:0] midgame;
      logic signed [15:0] endgame;
      logic               bad;
   } score_type;

   logic signed [15:0] feat_w [HBIAS_BASE];
   logic signed [15:0] hid_bias [NEURONS];
   logic signed [15:0] out_w [2 * NEURONS];
   logic signed [15:0] out_bias [2];
   score_type          score_q [$];

   assign pending = score_q.size();

   function automatic logic signed [15:0] trunc_sat(input longint q);
      longint v;
      v = q / 65536;
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      return v[15:0];
   endfunction

   function automatic score_type score_position(input logic [63:0] pawns, kings, black);
      longint    acc [NEURONS];
      longint    o0, o1, h;
      int        kcount, used, feat;
      logic [63:0] live;
      score_type s;
      for (int n = 0; n < NEURONS; n++) acc[n] = hid_bias[n];
      live = pawns & ~BACK_RANKS;
      kcount = 0;
      used = 0;
      for (int sq = 0; sq <= SQ_LAST; sq++) begin
         if (live[sq]) begin
            feat = COLOUR_OFS * black[sq] + sq - PAWN_OFS;
            for (int n = 0; n < NEURONS; n++) acc[n] += feat_w[feat * NEURONS + n];
         end
      end
      for (int sq = 0; sq <= SQ_LAST; sq++) begin
         if (kings[sq]) begin
            kcount++;
            if (used < 2) begin
               feat = COLOUR_OFS * black[sq] + KING_OFS + sq;
               for (int n = 0; n < NEURONS; n++) acc[n] += feat_w[feat * NEURONS + n];
               used++;
            end
         end
      end
      o0 = longint'(out_bias[0]) * 256;
      o1 = longint'(out_bias[1]) * 256;
      for (int n = 0; n < NEURONS; n++) begin
         h = acc[n];
         if (h < 0) h = 0;
         if (h > longint'(HIDDEN_MAX)) h = HIDDEN_MAX;
         o0 += h * out_w[2 * n];
         o1 += h * out_w[2 * n + 1];
      end
      s.midgame = trunc_sat(o0);
      s.endgame = trunc_sat(o1);
      s.bad = (kcount != 2) || ((pawns & BACK_RANKS) != 0);
      return s;
   endfunction

   always @(posedge clock) begin
      score_type exp_s;
      int        a;
      if (reset) begin
         fail_count <= 0;
      end else begin
         if (req_valid && !req_stall) begin
            a = req_weight_address;
            if (req_opcode == OP_LOAD) begin
               if (a < HBIAS_BASE) feat_w[a] = req_weight_value;
               else if (a < OW_BASE) hid_bias[a - HBIAS_BASE] = req_weight_value;
               else if (a < OB_BASE) out_w[a - OW_BASE] = req_weight_value;
               else if (a < MAP_END) out_bias[a - OB_BASE] = req_weight_value;
            end else begin
               score_q.push_back(score_position(req_pawn_squares, req_king_squares,
                                                req_black_squares));
            end
         end
         if (rsp_valid && !rsp_stall) begin
            if (score_q.size() == 0) begin
               $display("%0t: unexpected score transaction mg %0d eg %0d bad %0b", $time,
                        rsp_midgame_score, rsp_endgame_score, rsp_bad_position);
               fail_count <= fail_count + 1;
            end else begin
               exp_s = score_q.pop_front();
               if (exp_s.midgame !== rsp_midgame_score || exp_s.endgame !== rsp_endgame_score
                   || exp_s.bad !== rsp_bad_position) begin
                  $display("%0t: score mismatch expected mg %0d eg %0d bad %0b, got %0d %0d %0b",
                           $time, exp_s.midgame, exp_s.endgame, exp_s.bad,
                           rsp_midgame_score, rsp_endgame_score, rsp_bad_position);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
   end

endmodule

[tb/pawn_king_mlp_evaluator_unit_tb.sv]
// testbench top of the pawn and king network evaluator: stimulus and verdict
`timescale 1ns / 100ps
module pawn_king_mlp_evaluator_unit_tb;
   import pkme_pkg::*;

   localparam int MAP_END   = 7266;
   localparam int WD_LIMIT  = 20000;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic               req_opcode = OP_LOAD;
   logic [12:0]        req_weight_address = '0;
   logic signed [15:0] req_weight_value = '0;
   logic [63:0]        req_pawn_squares = '0;
   logic [63:0]        req_king_squares = '0;
   logic [63:0]        req_black_squares = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic signed [15:0] rsp_midgame_score;
   logic signed [15:0] rsp_endgame_score;
   logic               rsp_bad_position;
   int                 fail_count;
   int                 pending;
   bit                 no_idle = 1'b0;
   int                 quiet_cycles;

   always #10 clock = ~clock;

   pawn_king_mlp_evaluator_unit u_dut (.*);

   pawn_king_mlp_evaluator_unit_checker u_checker (.*);

   always @(posedge clock) begin
      if (reset) rsp_stall <= 1'b0;
      else rsp_stall <= !no_idle && ($urandom_range(99) < 32);
   end

   // watchdog on channel activity
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > WD_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   task automatic send(input logic op, input logic [12:0] addr, input logic [15:0] val,
                       input logic [63:0] p, k, b);
      while (!no_idle && $urandom_range(99) < 32) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_opcode         <= op;
      req_weight_address <= addr;
      req_weight_value   <= val;
      req_pawn_squares   <= p;
      req_king_squares   <= k;
      req_black_squares  <= b;
      @(negedge clock);
      while (req_stall) @(negedge clock);
      @(posedge clock);
   endtask

   task automatic load(input int addr, input logic [15:0] val);
      send(OP_LOAD, addr[12:0], val, {$urandom, $urandom}, {$urandom, $urandom},
           {$urandom, $urandom});
   endtask

   task automatic evaluate(input logic [63:0] p, k, b);
      send(OP_EVAL, 13'($urandom), 16'($urandom), p, k, b);
   endtask

   // fill the whole map: 0 all max, 1 max inputs with min output weights, 2 random
   task automatic fill_store(input int mode);
      logic [15:0] v;
      for (int a = 0; a < MAP_END; a++) begin
         if (mode == 0) v = 16'h7FFF;
         else if (mode == 1) v = (a >= 7200 && a < 7264) ? 16'h8000 : 16'h7FFF;
         else v = 16'($urandom);
         load(a, v);
      end
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (pending != 0) @(posedge clock);
      repeat (120) @(posedge clock);
   endtask

   task automatic random_position();
      logic [63:0] p, k;
      int          r;
      r = $urandom_range(99);
      if (r < 80) begin
         k = '0;
         k[$urandom_range(63)] = 1'b1;
         k[$urandom_range(63)] = 1'b1;
         p = '0;
         repeat ($urandom_range(16)) p[$urandom_range(55, 8)] = 1'b1;
         if ($urandom_range(9) == 0) p[$urandom_range(63)] = 1'b1;
      end else begin
         p = {$urandom, $urandom} & {$urandom, $urandom};
         k = {$urandom, $urandom};
         if (r < 90) k = k & {$urandom, $urandom} & {$urandom, $urandom};
      end
      evaluate(p, k, {$urandom, $urandom});
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      fill_store(0);
      evaluate('1, '1, '1);
      evaluate(64'h00FF_0000_0000_FF00, 64'h1000_0000_0000_0010, 64'hFFFF_0000_0000_0000);
      drain();

      fill_store(1);
      evaluate(64'h00FF_0000_0000_FF00, 64'h1000_0000_0000_0010, 64'h0);
      evaluate('0, '0, '0);
      drain();

      fill_store(2);
      evaluate('0, '0, '0);
      evaluate('0, 64'h8000_0000_0000_0001, '0);
      evaluate('0, 64'h8000_0000_0000_0001, '1);
      evaluate('0, 64'h0000_0000_0000_0007, 64'h5);
      evaluate('0, 64'h0000_0000_0000_0001, '0);
      evaluate(64'hFF00_0000_0000_00FF, 64'h0100_0000_0000_0080, '0);
      evaluate(64'h0000_0000_0000_0100, 64'h0000_0000_0000_0003, '1);
      evaluate(64'h0080_0000_0000_0000, 64'h0000_0000_0000_0003, 64'h0080_0000_0000_0000);
      evaluate('1, '1, '0);
      evaluate(64'h00FF_FFFF_FFFF_FF00, 64'h0000_0000_0000_0011, 64'hAAAA_AAAA_AAAA_AAAA);
      load(8191, 16'h7FFF);
      load(MAP_END, 16'h8000);
      evaluate(64'h0000_0000_0000_FF00, 64'h0000_0000_0000_0011, '0);
      drain();

      for (int i = 0; i < 400; i++) begin
         no_idle = (i >= 150 && i < 230);
         if (i == 300) drain();
         if ($urandom_range(99) < 30) begin
            if ($urandom_range(3) == 0) load($urandom_range(8191), 16'($urandom));
            else load($urandom_range(MAP_END - 1), 16'($urandom));
         end else begin
            random_position();
         end
      end
      no_idle = 1'b0;
      drain();

      if (fail_count == 0 && pending == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

[pawn_king_mlp_evaluator_unit.f]
design/pkme_pkg.sv
design/pkme_lane.sv
design/pawn_king_mlp_evaluator_unit.sv
design/pkme_checker.sv
tb/pawn_king_mlp_evaluator_unit_checker.sv
tb/pawn_king_mlp_evaluator_unit_tb.sv
